// ----- rtl/bgauge_pkg.sv -----
// Shared types, constants and helper functions of the battery gauge.
// Used by the channel interfaces, the controller, the datapath and the top level.
// Depends on nothing else.
package bgauge_pkg;

	localparam int unsigned ADC_W      = 12;
	localparam int unsigned MV_W       = 14;
	localparam int unsigned PCT_W      = 7;
	localparam int unsigned LEVEL_W    = 2;
	localparam int unsigned MODE_W     = 2;
	localparam int unsigned TIMER_W    = 24;
	localparam int unsigned GAIN_W     = 18;
	localparam int unsigned GAIN_FRAC  = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 24;

	localparam int unsigned SAMPLES_DEF = 16;

	typedef enum logic [MODE_W-1:0] {
		MODE_TICK     = 2'd0,
		MODE_SAMPLE   = 2'd1,
		MODE_ACTIVITY = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN     = 3'd0,
		REG_CRIT_MV  = 3'd1,
		REG_CHECK_MS = 3'd2,
		REG_LIGHT_MS = 3'd3,
		REG_DEEP_MS  = 3'd4
	} cfg_reg_t;

	typedef enum logic [LEVEL_W-1:0] {
		LEVEL_FULL     = 2'd0,
		LEVEL_GOOD     = 2'd1,
		LEVEL_LOW      = 2'd2,
		LEVEL_CRITICAL = 2'd3
	} level_t;

	localparam logic [GAIN_W-1:0]  GAIN_RST  = 18'd105626;
	localparam logic [MV_W-1:0]    CRIT_RST  = 14'd3300;
	localparam logic [TIMER_W-1:0] CHECK_RST = 24'd30000;
	localparam logic [TIMER_W-1:0] LIGHT_RST = 24'd30000;
	localparam logic [TIMER_W-1:0] DEEP_RST  = 24'd300000;
	localparam logic [MV_W-1:0]    VOLT_RST  = 14'd3700;
	localparam logic [PCT_W-1:0]   PCT_RST   = 7'd80;

	localparam logic [PCT_W-1:0] PCT_FULL_ABOVE = 7'd80;
	localparam logic [PCT_W-1:0] PCT_GOOD_ABOVE = 7'd40;
	localparam logic [PCT_W-1:0] PCT_LOW_ABOVE  = 7'd10;

	// LiPo discharge curve breakpoints.
	localparam int unsigned NUM_BP = 8;
	localparam int unsigned NUM_SEG = NUM_BP - 1;
	localparam int unsigned SEG_W = 3;
	localparam logic [MV_W-1:0] BP_MV [NUM_BP] = '{
		14'd3300, 14'd3500, 14'd3600, 14'd3700, 14'd3800, 14'd3950, 14'd4100, 14'd4200
	};
	localparam logic [PCT_W-1:0] BP_PCT [NUM_BP] = '{
		7'd0, 7'd15, 7'd30, 7'd45, 7'd60, 7'd75, 7'd90, 7'd100
	};

	localparam int unsigned SEG_DIFF_W = 8;
	localparam int unsigned RISE_W = 4;
	localparam int unsigned X_W = 12;
	localparam int unsigned RECIP_SHIFT = 20;
	localparam int unsigned RECIP_W = 14;
	localparam int unsigned STEP_W = X_W + RECIP_W - RECIP_SHIFT;

	localparam logic [RISE_W-1:0] SEG_RISE [NUM_SEG] = '{
		RISE_W'(BP_PCT[1] - BP_PCT[0]), RISE_W'(BP_PCT[2] - BP_PCT[1]),
		RISE_W'(BP_PCT[3] - BP_PCT[2]), RISE_W'(BP_PCT[4] - BP_PCT[3]),
		RISE_W'(BP_PCT[5] - BP_PCT[4]), RISE_W'(BP_PCT[6] - BP_PCT[5]),
		RISE_W'(BP_PCT[7] - BP_PCT[6])
	};

	// Rounded-up reciprocals of the segment spans. With products below 2^12 the
	// error stays under one span step, so the truncated quotient is exact.
	localparam logic [RECIP_W-1:0] SEG_RECIP [NUM_SEG] = '{
		RECIP_W'((32'd1 << RECIP_SHIFT) / (BP_MV[1] - BP_MV[0]) + 1),
		RECIP_W'((32'd1 << RECIP_SHIFT) / (BP_MV[2] - BP_MV[1]) + 1),
		RECIP_W'((32'd1 << RECIP_SHIFT) / (BP_MV[3] - BP_MV[2]) + 1),
		RECIP_W'((32'd1 << RECIP_SHIFT) / (BP_MV[4] - BP_MV[3]) + 1),
		RECIP_W'((32'd1 << RECIP_SHIFT) / (BP_MV[5] - BP_MV[4]) + 1),
		RECIP_W'((32'd1 << RECIP_SHIFT) / (BP_MV[6] - BP_MV[5]) + 1),
		RECIP_W'((32'd1 << RECIP_SHIFT) / (BP_MV[7] - BP_MV[6]) + 1)
	};

	// Segment whose lower breakpoint is the last one at or below v, limited to the first and last segments.
	function automatic logic [SEG_W-1:0] seg_of(input logic [MV_W-1:0] v);
		logic [SEG_W-1:0] n;
		n = '0;
		for (int k = 1; k < NUM_SEG; k++) begin
			if (v >= BP_MV[k]) begin
				n = n + SEG_W'(1);
			end
		end
		return n;
	endfunction

	typedef enum logic [2:0] {
		OP_NONE,
		OP_EXEC,
		OP_DIV1,
		OP_DIV2,
		OP_GAIN,
		OP_SEG,
		OP_PCT,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic last_sample;
		logic out_free;
	} stat_t;

endpackage

// ----- rtl/bgauge_if.sv -----
// Valid/ready channel interfaces of the battery gauge: input items,
// result items and configuration writes. Depends on bgauge_pkg.
interface bgauge_item_if import bgauge_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [ADC_W-1:0]  adc_raw;

	modport source (output valid, mode, adc_raw, input ready);
	modport sink (input valid, mode, adc_raw, output ready);
endinterface

interface bgauge_result_if import bgauge_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [MV_W-1:0]    battery_mv;
	logic [PCT_W-1:0]   percent;
	logic [LEVEL_W-1:0] level;
	logic               critical_battery;
	logic               reading_updated;
	logic               sample_request;
	logic               light_sleep_due;
	logic               deep_sleep_due;

	modport source (
		output valid, battery_mv, percent, level, critical_battery, reading_updated,
			sample_request, light_sleep_due, deep_sleep_due,
		input ready
	);
	modport sink (
		input valid, battery_mv, percent, level, critical_battery, reading_updated,
			sample_request, light_sleep_due, deep_sleep_due,
		output ready
	);
endinterface

interface bgauge_cfg_if import bgauge_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/bgauge_ctrl.sv -----
// Controller of the battery gauge: sequences the datapath through the
// averaging, scaling and interpolation steps. Depends on bgauge_pkg.
module bgauge_ctrl import bgauge_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV1,
		ST_DIV2,
		ST_GAIN,
		ST_SEG,
		ST_PCT,
		ST_EMIT
	} state_t;

	state_t state_q;

	always_comb begin
		item_ready = (state_q == ST_IDLE);
		cmd.op = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.op = OP_EXEC;
				end
			end
			ST_DIV1: cmd.op = OP_DIV1;
			ST_DIV2: cmd.op = OP_DIV2;
			ST_GAIN: cmd.op = OP_GAIN;
			ST_SEG:  cmd.op = OP_SEG;
			ST_PCT:  cmd.op = OP_PCT;
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.op = OP_EMIT;
				end
			end
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= stat.last_sample ? ST_DIV1 : ST_EMIT;
					end
				end
				ST_DIV1: state_q <= ST_DIV2;
				ST_DIV2: state_q <= ST_GAIN;
				ST_GAIN: state_q <= ST_SEG;
				ST_SEG:  state_q <= ST_PCT;
				ST_PCT:  state_q <= ST_EMIT;
				ST_EMIT: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/bgauge_dpath.sv -----
// Datapath of the battery gauge: configuration registers, timers, sample
// accumulator, divide/scale/interpolate steps and the result register.
// Depends on bgauge_pkg and the channel interfaces in bgauge_if.sv.
module bgauge_dpath import bgauge_pkg::*; #(
	parameter int unsigned SAMPLES = SAMPLES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output stat_t                 stat,
	input  logic [MODE_W-1:0]     item_mode,
	input  logic [ADC_W-1:0]      item_adc_raw,
	bgauge_cfg_if.sink            cfg,
	bgauge_result_if.source       result
);

	localparam int unsigned SUM_W     = ADC_W + $clog2(SAMPLES);
	localparam int unsigned CNT_W     = $clog2(SAMPLES + 1);
	localparam int unsigned DIV_M_W   = SUM_W + 1;
	localparam int unsigned QPROD_W   = SUM_W + DIV_M_W;
	localparam int unsigned MV_PROD_W = ADC_W + GAIN_W;
	// Truncated reciprocal of SAMPLES; the quotient it gives is low by at most one.
	localparam logic [DIV_M_W-1:0] DIV_M = DIV_M_W'((64'd1 << SUM_W) / SAMPLES);
	localparam logic [TIMER_W-1:0] IDLE_MAX = '1;

	// Configuration registers
	logic [GAIN_W-1:0]  gain_q;
	logic [MV_W-1:0]    crit_q;
	logic [TIMER_W-1:0] check_q;
	logic [TIMER_W-1:0] light_q;
	logic [TIMER_W-1:0] deep_q;

	// Gauge state
	logic [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [MV_W-1:0]    volt_q;
	logic [PCT_W-1:0]   pct_q;
	logic [TIMER_W-1:0] check_timer_q;
	logic [TIMER_W-1:0] idle_q;
	logic               upd_q;
	logic               req_q;
	logic               res_valid_q;

	// Working registers
	logic [QPROD_W-1:0]    qprod_q;
	logic [ADC_W-1:0]      avg_q;
	logic [X_W-1:0]        x_q;
	logic [SEG_W-1:0]      seg_q;
	logic                  lo_q;
	logic                  hi_q;

	// Result payload registers
	logic [MV_W-1:0]    res_mv_q;
	logic [PCT_W-1:0]   res_pct_q;
	logic [LEVEL_W-1:0] res_level_q;
	logic               res_crit_q;
	logic               res_upd_q;
	logic               res_req_q;
	logic               res_light_q;
	logic               res_deep_q;

	logic [TIMER_W-1:0]    check_inc;
	logic [ADC_W-1:0]      quot0;
	logic [SUM_W-1:0]      rem;
	logic [MV_PROD_W-1:0]  mv_prod;
	logic [SEG_W-1:0]      seg;
	logic [SEG_DIFF_W-1:0] diff;
	logic [X_W+RECIP_W-1:0] step_prod;
	logic [PCT_W-1:0]      pct_interp;
	level_t                level;

	assign check_inc = check_timer_q + TIMER_W'(1);
	assign quot0 = qprod_q[SUM_W +: ADC_W];
	assign rem = sum_q - SUM_W'(quot0 * SAMPLES);
	assign mv_prod = avg_q * gain_q;
	assign seg = seg_of(volt_q);
	assign diff = SEG_DIFF_W'(volt_q - BP_MV[seg]);
	assign step_prod = x_q * SEG_RECIP[seg_q];
	assign pct_interp = BP_PCT[seg_q] + PCT_W'(step_prod[RECIP_SHIFT +: STEP_W]);

	always_comb begin
		if (pct_q > PCT_FULL_ABOVE) begin
			level = LEVEL_FULL;
		end else if (pct_q > PCT_GOOD_ABOVE) begin
			level = LEVEL_GOOD;
		end else if (pct_q > PCT_LOW_ABOVE) begin
			level = LEVEL_LOW;
		end else begin
			level = LEVEL_CRITICAL;
		end
	end

	assign stat.last_sample = (mode_t'(item_mode) == MODE_SAMPLE) &&
		((cnt_q + CNT_W'(1)) == CNT_W'(SAMPLES));
	assign stat.out_free = !res_valid_q || result.ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= GAIN_RST;
			crit_q  <= CRIT_RST;
			check_q <= CHECK_RST;
			light_q <= LIGHT_RST;
			deep_q  <= DEEP_RST;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_GAIN:     gain_q  <= cfg.data[GAIN_W-1:0];
				REG_CRIT_MV:  crit_q  <= cfg.data[MV_W-1:0];
				REG_CHECK_MS: check_q <= cfg.data[TIMER_W-1:0];
				REG_LIGHT_MS: light_q <= cfg.data[TIMER_W-1:0];
				REG_DEEP_MS:  deep_q  <= cfg.data[TIMER_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q         <= '0;
			cnt_q         <= '0;
			volt_q        <= VOLT_RST;
			pct_q         <= PCT_RST;
			check_timer_q <= '0;
			idle_q        <= '0;
			upd_q         <= 1'b0;
			req_q         <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			case (cmd.op)
				OP_EXEC: begin
					upd_q <= 1'b0;
					req_q <= 1'b0;
					case (mode_t'(item_mode))
						MODE_TICK: begin
							if (check_inc >= check_q) begin
								req_q         <= 1'b1;
								check_timer_q <= '0;
							end else begin
								check_timer_q <= check_inc;
							end
							if (idle_q != IDLE_MAX) begin
								idle_q <= idle_q + TIMER_W'(1);
							end
						end
						MODE_SAMPLE: begin
							sum_q <= sum_q + SUM_W'(item_adc_raw);
							cnt_q <= cnt_q + CNT_W'(1);
						end
						MODE_ACTIVITY: idle_q <= '0;
						default: ;
					endcase
				end
				// The 30-bit product shifted by the Q16 point fits 14 bits exactly,
				// so no clamp is needed.
				OP_GAIN: volt_q <= mv_prod[GAIN_FRAC +: MV_W];
				OP_PCT: begin
					if (lo_q) begin
						pct_q <= BP_PCT[0];
					end else if (hi_q) begin
						pct_q <= BP_PCT[NUM_BP-1];
					end else begin
						pct_q <= pct_interp;
					end
					sum_q <= '0;
					cnt_q <= '0;
					upd_q <= 1'b1;
				end
				default: ;
			endcase

			if (cmd.op == OP_EMIT) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_DIV1: qprod_q <= sum_q * DIV_M;
			OP_DIV2: avg_q <= quot0 + ADC_W'(rem >= SUM_W'(SAMPLES));
			OP_SEG: begin
				seg_q <= seg;
				x_q   <= X_W'(diff) * X_W'(SEG_RISE[seg]);
				lo_q  <= (volt_q <= BP_MV[0]);
				hi_q  <= (volt_q >= BP_MV[NUM_BP-1]);
			end
			OP_EMIT: begin
				res_mv_q    <= volt_q;
				res_pct_q   <= pct_q;
				res_level_q <= level;
				res_crit_q  <= (volt_q < crit_q);
				res_upd_q   <= upd_q;
				res_req_q   <= req_q;
				res_light_q <= (idle_q > light_q);
				res_deep_q  <= (idle_q > deep_q);
			end
			default: ;
		endcase
	end

	assign result.valid            = res_valid_q;
	assign result.battery_mv       = res_mv_q;
	assign result.percent          = res_pct_q;
	assign result.level            = res_level_q;
	assign result.critical_battery = res_crit_q;
	assign result.reading_updated  = res_upd_q;
	assign result.sample_request   = res_req_q;
	assign result.light_sleep_due  = res_light_q;
	assign result.deep_sleep_due   = res_deep_q;

endmodule

// ----- rtl/battery_gauge_with_idle_timers.sv -----
// Top level of the battery gauge with idle timers: joins the controller and
// the datapath. Depends on bgauge_pkg, bgauge_if.sv, bgauge_ctrl and bgauge_dpath.
//
//   Channel  Direction  Payload
//   item     in         mode, adc_raw
//   result   out        battery_mv, percent, level, critical_battery,
//                       reading_updated, sample_request, light_sleep_due,
//                       deep_sleep_due
//   cfg      in         index, data (always ready)
//
// Ticks, activity events and samples that do not complete an average pass
// through acceptance and loading of the result register. The sample that
// completes an average also passes the reciprocal divide, gain multiply and
// interpolation multiply, in sequence through one datapath.
// Reset is asynchronous and takes effect at once; there is no clearing pass.
// The result register holds while stalled and a new transaction is accepted
// meanwhile, but the next result waits until the register is taken.
module battery_gauge_with_idle_timers import bgauge_pkg::*; #(
	parameter int unsigned SAMPLES = SAMPLES_DEF
) (
	input logic             clk,
	input logic             arst_n,
	bgauge_item_if.sink     item,
	bgauge_result_if.source result,
	bgauge_cfg_if.sink      cfg
);

	cmd_t  cmd;
	stat_t stat;
	logic  item_ready;

	assign item.ready = item_ready;

	bgauge_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	bgauge_dpath #(
		.SAMPLES (SAMPLES)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.item_mode    (item.mode),
		.item_adc_raw (item.adc_raw),
		.cfg          (cfg),
		.result       (result)
	);

endmodule
